// ===== rtl/owbm_pkg.sv =====
// Shared types and constants of the one-wire bus master.
package owbm_pkg;

    // Byte framing
    localparam int BitsPerByte = 8;
    localparam int BitIdxW     = $clog2(BitsPerByte);

    // Timing register bank
    localparam int CfgCount  = 7;
    localparam int CfgAddrW  = 3;
    localparam int CfgDataW  = 16;
    localparam int TickW     = 16;

    // Register indexes
    localparam logic [CfgAddrW-1:0] REG_RESET_LOW  = 3'd0;
    localparam logic [CfgAddrW-1:0] REG_PRES_WAIT  = 3'd1;
    localparam logic [CfgAddrW-1:0] REG_RESET_TAIL = 3'd2;
    localparam logic [CfgAddrW-1:0] REG_WR1_LOW    = 3'd3;
    localparam logic [CfgAddrW-1:0] REG_WR0_LOW    = 3'd4;
    localparam logic [CfgAddrW-1:0] REG_SLOT_TAIL  = 3'd5;
    localparam logic [CfgAddrW-1:0] REG_READ_LOW   = 3'd6;

    // Register reset values
    localparam logic [TickW-1:0] RST_RESET_LOW  = 16'd480;
    localparam logic [TickW-1:0] RST_PRES_WAIT  = 16'd80;
    localparam logic [TickW-1:0] RST_RESET_TAIL = 16'd400;
    localparam logic [TickW-1:0] RST_WR1_LOW    = 16'd1;
    localparam logic [TickW-1:0] RST_WR0_LOW    = 16'd50;
    localparam logic [TickW-1:0] RST_SLOT_TAIL  = 16'd50;
    localparam logic [TickW-1:0] RST_READ_LOW   = 16'd1;

    // Recovery after a write-zero low time
    localparam logic [TickW-1:0] WR0_RECOVERY = 16'd1;

    // Item kinds
    localparam logic KIND_COMMAND = 1'b0;
    localparam logic KIND_TICK    = 1'b1;

    // Commands
    typedef enum logic [1:0] {
        CMD_RESET = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd;

    // Bus sequencer phases
    typedef enum logic [5:0] {
        PH_IDLE     = 6'b000001,
        PH_RST_LOW  = 6'b000010,
        PH_RST_WAIT = 6'b000100,
        PH_RST_TAIL = 6'b001000,
        PH_BIT_LOW  = 6'b010000,
        PH_BIT_TAIL = 6'b100000
    } t_phase;

endpackage

// ===== rtl/owbm_in_if.sv =====
// Input channel of the one-wire bus master: commands and microsecond ticks.
interface owbm_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [1:0] command;
    logic [7:0] write_data;
    logic       line_in;

    modport source (output valid, output kind, output command, output write_data,
                    output line_in, input ready);
    modport sink   (input valid, input kind, input command, input write_data,
                    input line_in, output ready);
endinterface

// ===== rtl/owbm_out_if.sv =====
// Result channel of the one-wire bus master.
interface owbm_out_if;
    logic       valid;
    logic       ready;
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_data;
    logic       rejected;

    modport source (output valid, output drive_low, output busy_res, output done_res,
                    output presence, output read_data, output rejected, input ready);
    modport sink   (input valid, input drive_low, input busy_res, input done_res,
                    input presence, input read_data, input rejected, output ready);
endinterface

// ===== rtl/one_wire_bus_master_unit.sv =====
// One-wire bus master: timing registers, bus sequencer and result register.
//
//   channel  | direction | transaction
//   ---------+-----------+--------------------------------------------------
//   i_in     | in        | command (reset, write byte, read byte) or tick
//   o_out    | out       | line drive, busy, done, presence, read byte, reject
//   i_cfg_*  | in        | write of one 16-bit timing register
//
// Each input transaction updates the sequencer state and the result register
// at the same edge; one transaction per cycle is sustained while results are
// taken. The result register is the only buffer; a new transaction enters in
// the cycle its predecessor leaves, and input stalls only while a result waits
// unclaimed. Synchronous active-low reset restores the default timings, idles
// the sequencer, clears its line drive and empties the result register.
module one_wire_bus_master_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    owbm_in_if.sink                           i_in,
    owbm_out_if.source                        o_out,
    input  logic                              i_cfg_we,
    input  logic [owbm_pkg::CfgAddrW-1:0]     i_cfg_addr,
    input  logic [owbm_pkg::CfgDataW-1:0]     i_cfg_wdata
);
    import owbm_pkg::*;

    // Timing registers
    logic [TickW-1:0]    r_cfg [CfgCount];

    // Sequencer state
    t_phase              r_phase,    n_phase;
    logic [1:0]          r_op,       n_op;
    logic [TickW-1:0]    r_tick,     n_tick;
    logic [BitIdxW-1:0]  r_bit,      n_bit;
    logic [7:0]          r_shift,    n_shift;
    logic                r_pres,     n_pres;
    logic                r_drive,    n_drive;
    logic [7:0]          r_last,     n_last;
    logic [TickW-1:0]    r_tail,     n_tail;

    // Result register
    logic                r_out_valid;
    logic                r_drive_o, r_busy_o, r_done_o, r_pres_o, r_rej_o;
    logic [7:0]          r_rdata_o;

    logic                in_fire;
    logic                n_done, n_rej, end_bit;
    logic [TickW-1:0]    tick_inc, limit, tail_len;
    logic                cur_bit;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_fire    = i_in.valid && i_in.ready;
    assign tick_inc   = (r_tick == {TickW{1'b1}}) ? r_tick : r_tick + TickW'(1);
    assign cur_bit    = r_shift[r_bit];

    // Write timing registers; indexes past the bank are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[REG_RESET_LOW]  <= RST_RESET_LOW;
            r_cfg[REG_PRES_WAIT]  <= RST_PRES_WAIT;
            r_cfg[REG_RESET_TAIL] <= RST_RESET_TAIL;
            r_cfg[REG_WR1_LOW]    <= RST_WR1_LOW;
            r_cfg[REG_WR0_LOW]    <= RST_WR0_LOW;
            r_cfg[REG_SLOT_TAIL]  <= RST_SLOT_TAIL;
            r_cfg[REG_READ_LOW]   <= RST_READ_LOW;
        end else if (i_cfg_we && (i_cfg_addr < CfgAddrW'(CfgCount))) begin
            r_cfg[i_cfg_addr] <= i_cfg_wdata;
        end
    end

    // Advance the sequencer by one transaction
    always_comb begin
        n_phase  = r_phase;
        n_op     = r_op;
        n_tick   = r_tick;
        n_bit    = r_bit;
        n_shift  = r_shift;
        n_pres   = r_pres;
        n_drive  = r_drive;
        n_last   = r_last;
        n_tail   = r_tail;
        n_done   = 1'b0;
        n_rej    = 1'b0;
        end_bit  = 1'b0;
        limit    = '0;
        tail_len = '0;

        if (in_fire) begin
            if (i_in.kind == KIND_COMMAND) begin
                // Start an operation, or reject when busy or unknown
                if (r_phase != PH_IDLE) begin
                    n_rej = 1'b1;
                end else begin
                    unique case (i_in.command)
                        CMD_RESET: begin
                            n_op    = CMD_RESET;
                            n_tick  = '0;
                            n_bit   = '0;
                            n_drive = 1'b1;
                            n_phase = PH_RST_LOW;
                        end
                        CMD_WRITE: begin
                            n_op    = CMD_WRITE;
                            n_tick  = '0;
                            n_bit   = '0;
                            n_drive = 1'b1;
                            n_shift = i_in.write_data;
                            n_phase = PH_BIT_LOW;
                        end
                        CMD_READ: begin
                            n_op    = CMD_READ;
                            n_tick  = '0;
                            n_bit   = '0;
                            n_drive = 1'b1;
                            n_shift = '0;
                            n_phase = PH_BIT_LOW;
                        end
                        default: begin
                            n_rej = 1'b1;
                        end
                    endcase
                end
            end else if (r_phase != PH_IDLE) begin
                // Count the tick and check the current interval
                n_tick = tick_inc;
                unique case (r_phase)
                    PH_RST_LOW: begin
                        if (tick_inc >= r_cfg[REG_RESET_LOW]) begin
                            n_drive = 1'b0;
                            n_tick  = '0;
                            n_phase = PH_RST_WAIT;
                        end
                    end
                    PH_RST_WAIT: begin
                        if (tick_inc >= r_cfg[REG_PRES_WAIT]) begin
                            n_pres = !i_in.line_in;
                            n_tick = '0;
                            if (r_cfg[REG_RESET_TAIL] == '0) begin
                                n_phase = PH_IDLE;
                                n_done  = 1'b1;
                            end else begin
                                n_phase = PH_RST_TAIL;
                            end
                        end
                    end
                    PH_RST_TAIL: begin
                        if (tick_inc >= r_cfg[REG_RESET_TAIL]) begin
                            n_phase = PH_IDLE;
                            n_done  = 1'b1;
                        end
                    end
                    PH_BIT_LOW: begin
                        if (r_op == CMD_READ) begin
                            limit    = r_cfg[REG_READ_LOW];
                            tail_len = r_cfg[REG_SLOT_TAIL];
                        end else if (cur_bit) begin
                            limit    = r_cfg[REG_WR1_LOW];
                            tail_len = r_cfg[REG_SLOT_TAIL];
                        end else begin
                            limit    = r_cfg[REG_WR0_LOW];
                            tail_len = WR0_RECOVERY;
                        end
                        if (tick_inc >= limit) begin
                            // Sample a read bit on the release tick
                            if (r_op == CMD_READ && i_in.line_in) begin
                                n_shift[r_bit] = 1'b1;
                            end
                            n_drive = 1'b0;
                            n_tick  = '0;
                            n_tail  = tail_len;
                            if (tail_len == '0) begin
                                end_bit = 1'b1;
                            end else begin
                                n_phase = PH_BIT_TAIL;
                            end
                        end
                    end
                    PH_BIT_TAIL: begin
                        if (tick_inc >= r_tail) begin
                            end_bit = 1'b1;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                        n_drive = 1'b0;
                    end
                endcase

                // Finish the byte or start the next slot
                if (end_bit) begin
                    if (r_bit == BitIdxW'(BitsPerByte - 1)) begin
                        if (r_op == CMD_READ) begin
                            n_last = n_shift;
                        end
                        n_phase = PH_IDLE;
                        n_drive = 1'b0;
                        n_done  = 1'b1;
                    end else begin
                        n_bit   = r_bit + BitIdxW'(1);
                        n_drive = 1'b1;
                        n_tick  = '0;
                        n_phase = PH_BIT_LOW;
                    end
                end
            end
        end
    end

    // Hold sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_op    <= CMD_RESET;
            r_tick  <= '0;
            r_bit   <= '0;
            r_shift <= '0;
            r_pres  <= 1'b0;
            r_drive <= 1'b0;
            r_last  <= '0;
            r_tail  <= '0;
        end else begin
            r_phase <= n_phase;
            r_op    <= n_op;
            r_tick  <= n_tick;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_pres  <= n_pres;
            r_drive <= n_drive;
            r_last  <= n_last;
            r_tail  <= n_tail;
        end
    end

    // Track result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Load the result payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_drive_o <= n_drive;
            r_busy_o  <= (n_phase != PH_IDLE);
            r_done_o  <= n_done;
            r_pres_o  <= n_pres;
            r_rdata_o <= n_last;
            r_rej_o   <= n_rej;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.drive_low = r_drive_o;
    assign o_out.busy_res  = r_busy_o;
    assign o_out.done_res  = r_done_o;
    assign o_out.presence  = r_pres_o;
    assign o_out.read_data = r_rdata_o;
    assign o_out.rejected  = r_rej_o;

endmodule

// ===== test/owbm_scoreboard.sv =====
// Scoreboard of the one-wire bus master: mirrors the sequencer and checks each result.
module owbm_scoreboard (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    owbm_in_if                             i_in_ch,
    owbm_out_if                            i_out_ch,
    input  logic                           i_cfg_we,
    input  logic [owbm_pkg::CfgAddrW-1:0]  i_cfg_addr,
    input  logic [owbm_pkg::CfgDataW-1:0]  i_cfg_wdata,
    output int                             o_errors,
    output int                             o_pending
);
    import owbm_pkg::*;

    typedef struct packed {
        logic       drive_low;
        logic       busy;
        logic       done;
        logic       presence;
        logic [7:0] read_data;
        logic       rejected;
    } t_bus_result;

    // Mirror of the timing bank and the sequencer
    logic [TickW-1:0]   timing [CfgCount];
    t_phase             seq_phase;
    t_cmd               cur_op;
    logic [TickW-1:0]   tick_cnt;
    logic [TickW-1:0]   tail_len;
    logic [BitIdxW-1:0] bit_idx;
    logic [7:0]         shreg;
    logic [7:0]         last_read;
    logic               pres_flag;
    logic               line_low;
    logic               op_done;

    t_bus_result        expected_q [$];
    t_bus_result        seen;
    t_bus_result        want;
    int                 err_cnt = 0;

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    task automatic report_error(input string msg);
        $display("[%0t] ERROR: %s", $time, msg);
        err_cnt++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] exp_val);
        if (got !== exp_val)
            report_error($sformatf("%s: got %0h, expected %0h", name, got, exp_val));
    endtask

    function automatic void clear_sequencer();
        timing[REG_RESET_LOW]  = RST_RESET_LOW;
        timing[REG_PRES_WAIT]  = RST_PRES_WAIT;
        timing[REG_RESET_TAIL] = RST_RESET_TAIL;
        timing[REG_WR1_LOW]    = RST_WR1_LOW;
        timing[REG_WR0_LOW]    = RST_WR0_LOW;
        timing[REG_SLOT_TAIL]  = RST_SLOT_TAIL;
        timing[REG_READ_LOW]   = RST_READ_LOW;
        seq_phase = PH_IDLE;
        cur_op    = CMD_RESET;
        tick_cnt  = '0;
        tail_len  = '0;
        bit_idx   = '0;
        shreg     = '0;
        last_read = '0;
        pres_flag = 1'b0;
        line_low  = 1'b0;
        op_done   = 1'b0;
    endfunction

    // Close a bit slot: finish the byte or pull low for the next bit
    function automatic void finish_bit();
        if (bit_idx == BitIdxW'(BitsPerByte - 1)) begin
            if (cur_op == CMD_READ)
                last_read = shreg;
            seq_phase = PH_IDLE;
            line_low  = 1'b0;
            op_done   = 1'b1;
        end else begin
            bit_idx   = bit_idx + 1'b1;
            line_low  = 1'b1;
            tick_cnt  = '0;
            seq_phase = PH_BIT_LOW;
        end
    endfunction

    // Release the line; a zero-length tail closes the slot on this tick
    function automatic void open_tail(input logic [TickW-1:0] len);
        line_low = 1'b0;
        tick_cnt = '0;
        tail_len = len;
        if (len == '0)
            finish_bit();
        else
            seq_phase = PH_BIT_TAIL;
    endfunction

    // Advance the running operation by one microsecond
    function automatic void advance_tick(input logic line);
        logic [TickW-1:0] lim;
        logic             cur;
        if (seq_phase == PH_IDLE)
            return;
        if (tick_cnt != '1)
            tick_cnt = tick_cnt + 1'b1;
        case (seq_phase)
            PH_RST_LOW: begin
                if (tick_cnt >= timing[REG_RESET_LOW]) begin
                    line_low  = 1'b0;
                    tick_cnt  = '0;
                    seq_phase = PH_RST_WAIT;
                end
            end
            PH_RST_WAIT: begin
                if (tick_cnt >= timing[REG_PRES_WAIT]) begin
                    pres_flag = !line;
                    tick_cnt  = '0;
                    if (timing[REG_RESET_TAIL] == '0) begin
                        seq_phase = PH_IDLE;
                        op_done   = 1'b1;
                    end else begin
                        seq_phase = PH_RST_TAIL;
                    end
                end
            end
            PH_RST_TAIL: begin
                if (tick_cnt >= timing[REG_RESET_TAIL]) begin
                    seq_phase = PH_IDLE;
                    op_done   = 1'b1;
                end
            end
            PH_BIT_LOW: begin
                cur = shreg[bit_idx];
                if (cur_op == CMD_READ)
                    lim = timing[REG_READ_LOW];
                else
                    lim = cur ? timing[REG_WR1_LOW] : timing[REG_WR0_LOW];
                if (tick_cnt >= lim) begin
                    if (cur_op == CMD_READ) begin
                        if (line)
                            shreg[bit_idx] = 1'b1;
                        open_tail(timing[REG_SLOT_TAIL]);
                    end else begin
                        open_tail(cur ? timing[REG_SLOT_TAIL] : WR0_RECOVERY);
                    end
                end
            end
            PH_BIT_TAIL: begin
                if (tick_cnt >= tail_len)
                    finish_bit();
            end
            default: ;
        endcase
    endfunction

    // Apply one input transaction and return the result it should produce
    function automatic t_bus_result predict_result(input logic kind, input logic [1:0] cmd,
                                                   input logic [7:0] wd, input logic line);
        t_bus_result r;
        logic        rej;
        op_done = 1'b0;
        rej     = 1'b0;
        if (kind == KIND_COMMAND) begin
            if (seq_phase != PH_IDLE || cmd > CMD_READ) begin
                rej = 1'b1;
            end else begin
                cur_op   = t_cmd'(cmd);
                tick_cnt = '0;
                bit_idx  = '0;
                line_low = 1'b1;
                if (cmd == CMD_RESET) begin
                    seq_phase = PH_RST_LOW;
                end else begin
                    shreg     = (cmd == CMD_WRITE) ? wd : 8'h00;
                    seq_phase = PH_BIT_LOW;
                end
            end
        end else begin
            advance_tick(line);
        end
        r.drive_low = line_low;
        r.busy      = (seq_phase != PH_IDLE);
        r.done      = op_done;
        r.presence  = pres_flag;
        r.read_data = last_read;
        r.rejected  = rej;
        return r;
    endfunction

    // Watch the channels: register writes, then results, then new transactions
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_sequencer();
            expected_q.delete();
        end else begin
            if (i_cfg_we && i_cfg_addr < CfgCount)
                timing[i_cfg_addr] = i_cfg_wdata;
            if (i_out_ch.valid && i_out_ch.ready) begin
                if (expected_q.size() == 0) begin
                    report_error("result transaction with nothing outstanding");
                end else begin
                    want           = expected_q.pop_front();
                    seen.drive_low = i_out_ch.drive_low;
                    seen.busy      = i_out_ch.busy_res;
                    seen.done      = i_out_ch.done_res;
                    seen.presence  = i_out_ch.presence;
                    seen.read_data = i_out_ch.read_data;
                    seen.rejected  = i_out_ch.rejected;
                    check_field("drive_low", 8'(seen.drive_low), 8'(want.drive_low));
                    check_field("busy_res", 8'(seen.busy), 8'(want.busy));
                    check_field("done_res", 8'(seen.done), 8'(want.done));
                    check_field("presence", 8'(seen.presence), 8'(want.presence));
                    check_field("read_data", seen.read_data, want.read_data);
                    check_field("rejected", 8'(seen.rejected), 8'(want.rejected));
                end
            end
            if (i_in_ch.valid && i_in_ch.ready)
                expected_q.push_back(predict_result(i_in_ch.kind, i_in_ch.command,
                                                    i_in_ch.write_data, i_in_ch.line_in));
        end
        o_pending <= expected_q.size();
        o_errors  <= err_cnt;
    end

endmodule

// ===== test/one_wire_bus_master_unit_tb.sv =====
// Testbench top of the one-wire bus master: stimulus, idling and the verdict.
module one_wire_bus_master_unit_tb;
    import owbm_pkg::*;

    localparam int               MaxCycles    = 200_000;
    localparam int               LineLow      = 0;
    localparam int               LineHigh     = 1;
    localparam int               LineRandom   = 2;
    localparam int               RandomPhases = 3;
    localparam int               PhaseItems   = 250;
    localparam int               DrainCycles  = 4;
    localparam logic [1:0]       CMD_BAD      = 2'd3;   // code outside the command set

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    logic [CfgAddrW-1:0] cfg_addr;
    logic [CfgDataW-1:0] cfg_wdata;
    logic                calm;
    int                  errors;
    int                  pending;
    int                  cycles = 0;
    int                  sink_hold;
    int                  sink_wait;
    logic [TickW-1:0]    timing [CfgCount];

    owbm_in_if  in_ch ();
    owbm_out_if out_ch ();

    one_wire_bus_master_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata)
    );

    owbm_scoreboard u_scoreboard (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_ch     (in_ch),
        .i_out_ch    (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stop a hung run
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == MaxCycles) begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side: hold ready low for a drawn number of cycles after each transaction
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
            sink_hold    <= 0;
        end else if (out_ch.valid && out_ch.ready) begin
            sink_wait     = calm ? 0 : $urandom_range(0, 8);
            out_ch.ready <= (sink_wait == 0);
            sink_hold    <= (sink_wait == 0) ? 0 : sink_wait - 1;
        end else if (sink_hold != 0) begin
            out_ch.ready <= 1'b0;
            sink_hold    <= sink_hold - 1;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    task automatic put_item(input logic kind, input logic [1:0] cmd,
                            input logic [7:0] wd, input logic line);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.kind       <= kind;
        in_ch.command    <= cmd;
        in_ch.write_data <= wd;
        in_ch.line_in    <= line;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic put_cmd(input logic [1:0] cmd, input logic [7:0] wd);
        put_item(KIND_COMMAND, cmd, wd, 1'($urandom));
    endtask

    task automatic put_ticks(input int n, input int line_mode);
        for (int k = 0; k < n; k++)
            put_item(KIND_TICK, 2'($urandom), 8'($urandom),
                     (line_mode == LineRandom) ? 1'($urandom) : (line_mode == LineHigh));
    endtask

    function automatic int at_least_one(input logic [TickW-1:0] v);
        return (v == '0) ? 1 : int'(v);
    endfunction

    // Ticks a command needs from start to done under the current timings
    function automatic int op_ticks(input logic [1:0] cmd, input logic [7:0] wd);
        int n;
        n = 0;
        case (cmd)
            CMD_RESET:
                n = at_least_one(timing[REG_RESET_LOW]) + at_least_one(timing[REG_PRES_WAIT])
                    + int'(timing[REG_RESET_TAIL]);
            CMD_WRITE:
                for (int b = 0; b < BitsPerByte; b++)
                    n += wd[b] ? at_least_one(timing[REG_WR1_LOW]) + int'(timing[REG_SLOT_TAIL])
                               : at_least_one(timing[REG_WR0_LOW]) + int'(WR0_RECOVERY);
            CMD_READ:
                n = BitsPerByte * (at_least_one(timing[REG_READ_LOW])
                                   + int'(timing[REG_SLOT_TAIL]));
            default: n = 0;
        endcase
        return n;
    endfunction

    // Ticks enough to finish whatever operation is running
    function automatic int finish_ticks();
        int n;
        n = op_ticks(CMD_RESET, 8'h00);
        if (op_ticks(CMD_WRITE, 8'h00) > n) n = op_ticks(CMD_WRITE, 8'h00);
        if (op_ticks(CMD_WRITE, 8'hFF) > n) n = op_ticks(CMD_WRITE, 8'hFF);
        if (op_ticks(CMD_READ, 8'h00) > n) n = op_ticks(CMD_READ, 8'h00);
        return n;
    endfunction

    task automatic run_op(input logic [1:0] cmd, input logic [7:0] wd, input int line_mode);
        put_cmd(cmd, wd);
        put_ticks(op_ticks(cmd, wd), line_mode);
    endtask

    // Drop valid and wait until every result has been taken
    task automatic settle();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DrainCycles) @(posedge clk);
    endtask

    // Write the whole timing bank from the local copy
    task automatic load_timings();
        for (int i = 0; i < CfgCount; i++) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= CfgAddrW'(i);
            cfg_wdata <= timing[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic shuffle_timings();
        for (int i = 0; i < CfgCount; i++)
            timing[i] = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(4, 12))
                                                    : 16'($urandom_range(0, 3));
    endtask

    // Mostly complete operations with random content, some cut short or padded
    task automatic random_ops(input int budget);
        int         used;
        int         len;
        int         pick;
        logic [1:0] cmd;
        logic [7:0] wd;
        used = 0;
        while (used < budget) begin
            calm = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 99);
            cmd  = (pick < 4) ? CMD_BAD : 2'($urandom_range(0, 2));
            wd   = 8'($urandom);
            len  = op_ticks(cmd, wd);
            put_cmd(cmd, wd);
            used += len + 1;
            pick = $urandom_range(0, 9);
            if (pick == 0)
                len = $urandom_range(0, len);
            else if (pick == 1)
                len += $urandom_range(1, 6);
            put_ticks(len, LineRandom);
        end
    endtask

    initial begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_addr         = '0;
        cfg_wdata        = '0;
        calm             = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.kind       = KIND_TICK;
        in_ch.command    = CMD_RESET;
        in_ch.write_data = 8'h00;
        in_ch.line_in    = 1'b1;
        out_ch.ready     = 1'b0;
        timing[REG_RESET_LOW]  = RST_RESET_LOW;
        timing[REG_PRES_WAIT]  = RST_PRES_WAIT;
        timing[REG_RESET_TAIL] = RST_RESET_TAIL;
        timing[REG_WR1_LOW]    = RST_WR1_LOW;
        timing[REG_WR0_LOW]    = RST_WR0_LOW;
        timing[REG_SLOT_TAIL]  = RST_SLOT_TAIL;
        timing[REG_READ_LOW]   = RST_READ_LOW;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Idle ticks and an unknown code while idle
        put_item(KIND_TICK, CMD_READ, 8'hFF, 1'b0);
        put_item(KIND_TICK, CMD_WRITE, 8'h00, 1'b1);
        put_cmd(CMD_BAD, 8'h00);

        // Default timings: a write of mixed bits with commands sent while busy
        put_cmd(CMD_WRITE, 8'h0F);
        put_ticks(10, LineHigh);
        put_cmd(CMD_RESET, 8'h00);
        put_cmd(CMD_BAD, 8'hFF);
        put_ticks(op_ticks(CMD_WRITE, 8'h0F) - 10, LineRandom);
        settle();

        // Zero low and tail times in every timing register
        foreach (timing[i]) timing[i] = '0;
        load_timings();
        run_op(CMD_RESET, 8'h00, LineLow);
        run_op(CMD_WRITE, 8'hA5, LineRandom);
        put_cmd(CMD_WRITE, 8'h5A);
        put_cmd(CMD_READ, 8'h00);
        put_ticks(op_ticks(CMD_WRITE, 8'h5A), LineRandom);
        run_op(CMD_READ, 8'h00, LineRandom);
        settle();

        // Random phases under short random timings
        for (int p = 0; p < RandomPhases; p++) begin
            shuffle_timings();
            load_timings();
            random_ops(PhaseItems);
            calm = ($urandom_range(0, 1) == 0);
            put_ticks(finish_ticks(), LineRandom);
            settle();
        end

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/owbm_pkg.sv
rtl/owbm_in_if.sv
rtl/owbm_out_if.sv
rtl/one_wire_bus_master_unit.sv
test/owbm_scoreboard.sv
test/one_wire_bus_master_unit_tb.sv
